// ===== rtl/bam_pkg.sv =====
// Shared types and constants of the border-aware 3x3 mean filter.
// Used by every module under rtl/; depends on nothing.
package bam_pkg;

    localparam int PX_W        = 8;
    localparam int POS_W       = 10;
    localparam int MEAN_W      = 16;
    localparam int SUM_W       = 12;
    localparam int NUM_W       = 20;
    localparam int RECIP_W     = 24;
    localparam int PROD_W      = 44;
    localparam int QUOT_LSB    = 24;
    localparam int TDATA_OUT_W = 40;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int FRAME_RESET = 1000;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        DIV_4 = 2'd0,
        DIV_6 = 2'd1,
        DIV_9 = 2'd2
    } div_t;

    typedef struct packed {
        logic            drain;
        logic [PX_W-1:0] px;
        logic            bank;
        logic            has_res;
        logic            top_cut;
        logic            left_cut;
        logic            right_cut;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } fetch_t;

    typedef struct packed {
        logic [PX_W-1:0] b0p0;
        logic [PX_W-1:0] b0p1;
        logic [PX_W-1:0] b1p0;
        logic [PX_W-1:0] b1p1;
    } line_rd_t;

    typedef struct packed {
        logic             two;
        logic [SUM_W-1:0] sum0;
        div_t             div0;
        logic [SUM_W-1:0] sum1;
        div_t             div1;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last0;
        logic             done;
    } sum_pair_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic              last;
        logic              done;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } result_pair_t;

    function automatic logic [2:0] div_round(input div_t d);
        logic [2:0] r;
        case (d)
            DIV_4:   r = 3'd2;
            DIV_6:   r = 3'd3;
            DIV_9:   r = 3'd4;
            default: r = 3'd2;
        endcase
        return r;
    endfunction

    // ceil(2^24 / n): exact quotient for any 20-bit numerator
    function automatic logic [RECIP_W-1:0] div_recip(input div_t d);
        logic [RECIP_W-1:0] m;
        case (d)
            DIV_4:   m = 24'h400000;
            DIV_6:   m = 24'h2AAAAB;
            DIV_9:   m = 24'h1C71C8;
            default: m = 24'h400000;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/border_aware_mean_3x3.sv =====
// Border-aware 3x3 mean filter: top level with frame size registers.
// Depends on bam_pkg, bam_fetch, bam_window, bam_divide, bam_outq.
// Path: fetch, sum and divide registers, then the result buffer, drive m_.
// Throughput: one transaction per cycle while m_tready is high; a right-edge
// sample yields two results, sent one at a time, and holds the input meanwhile.
// Reset: synchronous, active low; clears position, pipeline valids and the
// result buffer, sets both frame sizes to 1000. The line store is not cleared.
module border_aware_mean_3x3 import bam_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [CFG_W-1:0]       cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [PX_W-1:0]        s_tdata,   // [7:0] height_sample
    input  logic [0:0]             s_tuser,   // [0] req_type (1 = drain tick)
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // [15:0] mean_value, [25:16] out_row,
                                              // [35:26] out_col, [39:36] zero
    output logic                   m_tlast,   // last_in_run
    output logic [0:0]             m_tuser    // [0] frame_done
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam logic [CW-1:0] WLAST_RESET =
        CW'(((FRAME_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_RESET) - 1);
    localparam logic [RW-1:0] HLAST_RESET =
        RW'(((FRAME_RESET > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_RESET) - 1);

    logic [CW-1:0] wlast_reg, wlast_next;
    logic [RW-1:0] hlast_reg, hlast_next;

    logic         a_valid, b_ready, b_valid, c_ready, c_valid, q_ready;
    fetch_t       a_item;
    line_rd_t     a_rd;
    sum_pair_t    b_item;
    result_pair_t c_item;

    always_comb begin
        wlast_next = wlast_reg;
        hlast_next = hlast_reg;
        if (cfg_wr_en && (cfg_wr_index == CFG_FRAME_WIDTH)) begin
            if (cfg_wr_data < CFG_W'(2)) begin
                wlast_next = CW'(1);
            end else if (32'(cfg_wr_data) > MAX_WIDTH) begin
                wlast_next = CW'(MAX_WIDTH - 1);
            end else begin
                wlast_next = CW'(cfg_wr_data - 1'b1);
            end
        end
        if (cfg_wr_en && (cfg_wr_index == CFG_FRAME_HEIGHT)) begin
            if (cfg_wr_data < CFG_W'(2)) begin
                hlast_next = RW'(1);
            end else if (32'(cfg_wr_data) > MAX_HEIGHT) begin
                hlast_next = RW'(MAX_HEIGHT - 1);
            end else begin
                hlast_next = RW'(cfg_wr_data - 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlast_reg <= WLAST_RESET;
            hlast_reg <= HLAST_RESET;
        end else begin
            wlast_reg <= wlast_next;
            hlast_reg <= hlast_next;
        end
    end

    bam_fetch #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_fetch (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .restart  (cfg_wr_en),
        .wlast    (wlast_reg),
        .hlast    (hlast_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_drain (s_tuser[0]),
        .in_px    (s_tdata),
        .b_ready  (b_ready),
        .a_valid  (a_valid),
        .a_item   (a_item),
        .a_rd     (a_rd)
    );

    bam_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .a_valid (a_valid),
        .a_item  (a_item),
        .a_rd    (a_rd),
        .b_ready (b_ready),
        .c_ready (c_ready),
        .b_valid (b_valid),
        .b_item  (b_item)
    );

    bam_divide u_divide (
        .aclk    (aclk),
        .aresetn (aresetn),
        .b_valid (b_valid),
        .b_item  (b_item),
        .c_ready (c_ready),
        .q_ready (q_ready),
        .c_valid (c_valid),
        .c_item  (c_item)
    );

    bam_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .c_valid  (c_valid),
        .c_item   (c_item),
        .q_ready  (q_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("frame_done without last_in_run");

    a_mean_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] <= 16'hFF00))
        else $error("mean above 255.0");

    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("second result of a right-edge sample missing");

endmodule

// ===== rtl/bam_fetch.sv =====
// Raster position tracking, two-bank line store and the fetch register stage.
// Depends on bam_pkg.
module bam_fetch import bam_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          restart,
    input  logic [$clog2(MAX_WIDTH)-1:0]  wlast,
    input  logic [$clog2(MAX_HEIGHT)-1:0] hlast,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_drain,
    input  logic [PX_W-1:0]               in_px,
    input  logic                          b_ready,
    output logic                          a_valid,
    output fetch_t                        a_item,
    output line_rd_t                      a_rd
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [RW-1:0] in_row_reg, in_row_next;
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [CW-1:0] drain_col_reg, drain_col_next;
    logic          draining_reg, draining_next;
    logic          a_valid_reg, a_valid_next;
    fetch_t        a_item_reg, a_item_next;
    logic [PX_W-1:0] b0p0_reg, b0p1_reg, b1p0_reg, b1p1_reg;

    logic [PX_W-1:0] bank0_mem [MAX_WIDTH];
    logic [PX_W-1:0] bank1_mem [MAX_WIDTH];

    logic          in_fire, take_sample, take_drain;
    logic          col_last, row_last, dcol_last;
    logic [CW-1:0] rd_addr0, rd_addr1;
    logic          wr_en0, wr_en1;

    assign in_ready    = !a_valid_reg || b_ready;
    assign in_fire     = in_valid && in_ready;
    assign take_sample = in_fire && !in_drain && !draining_reg;
    assign take_drain  = in_fire && in_drain && draining_reg;
    assign col_last    = (in_col_reg == wlast);
    assign row_last    = (in_row_reg == hlast);
    assign dcol_last   = (drain_col_reg == wlast);
    assign rd_addr0    = draining_reg ? drain_col_reg : in_col_reg;
    assign rd_addr1    = dcol_last ? drain_col_reg : CW'(drain_col_reg + 1'b1);
    assign wr_en0      = take_sample && !in_row_reg[0];
    assign wr_en1      = take_sample && in_row_reg[0];

    always_comb begin
        in_row_next    = in_row_reg;
        in_col_next    = in_col_reg;
        drain_col_next = drain_col_reg;
        draining_next  = draining_reg;
        if (restart) begin
            in_row_next    = '0;
            in_col_next    = '0;
            drain_col_next = '0;
            draining_next  = 1'b0;
        end else if (take_sample) begin
            if (col_last) begin
                in_col_next = '0;
                if (row_last) begin
                    in_row_next    = '0;
                    draining_next  = 1'b1;
                    drain_col_next = '0;
                end else begin
                    in_row_next = RW'(in_row_reg + 1'b1);
                end
            end else begin
                in_col_next = CW'(in_col_reg + 1'b1);
            end
        end else if (take_drain) begin
            if (dcol_last) begin
                draining_next  = 1'b0;
                drain_col_next = '0;
            end else begin
                drain_col_next = CW'(drain_col_reg + 1'b1);
            end
        end
    end

    always_comb begin
        a_item_next.drain = draining_reg;
        a_item_next.px    = in_px;
        a_item_next.bank  = in_row_reg[0];
        if (draining_reg) begin
            a_item_next.has_res   = 1'b1;
            a_item_next.top_cut   = 1'b0;
            a_item_next.left_cut  = (drain_col_reg == '0);
            a_item_next.right_cut = dcol_last;
            a_item_next.row       = POS_W'(hlast);
            a_item_next.col       = POS_W'(drain_col_reg);
        end else begin
            a_item_next.has_res   = (in_row_reg != '0) && (in_col_reg != '0);
            a_item_next.top_cut   = (in_row_reg < RW'(2));
            a_item_next.left_cut  = (in_col_reg < CW'(2));
            a_item_next.right_cut = col_last;
            a_item_next.row       = POS_W'(RW'(in_row_reg - 1'b1));
            a_item_next.col       = POS_W'(CW'(in_col_reg - 1'b1));
        end
        if (in_ready) begin
            a_valid_next = take_sample || take_drain;
        end else begin
            a_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            drain_col_reg <= '0;
            draining_reg  <= 1'b0;
            a_valid_reg   <= 1'b0;
        end else begin
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            drain_col_reg <= drain_col_next;
            draining_reg  <= draining_next;
            a_valid_reg   <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            a_item_reg <= a_item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            b0p0_reg <= bank0_mem[rd_addr0];
            b0p1_reg <= bank0_mem[rd_addr1];
        end
        if (wr_en0) begin
            bank0_mem[in_col_reg] <= in_px;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            b1p0_reg <= bank1_mem[rd_addr0];
            b1p1_reg <= bank1_mem[rd_addr1];
        end
        if (wr_en1) begin
            bank1_mem[in_col_reg] <= in_px;
        end
    end

    assign a_valid = a_valid_reg;
    assign a_item  = a_item_reg;
    assign a_rd    = {b0p0_reg, b0p1_reg, b1p0_reg, b1p1_reg};

endmodule

// ===== rtl/bam_window.sv =====
// 3x3 window shift, border-masked column sums and the sum register stage.
// Depends on bam_pkg.
module bam_window import bam_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      a_valid,
    input  fetch_t    a_item,
    input  line_rd_t  a_rd,
    output logic      b_ready,
    input  logic      c_ready,
    output logic      b_valid,
    output sum_pair_t b_item
);

    logic [PX_W-1:0] win_reg  [3][3];
    logic [PX_W-1:0] win_next [3][3];
    logic [PX_W:0]   prev_reg;
    logic            b_valid_reg, b_valid_next;
    sum_pair_t       b_item_reg, b_item_next;

    logic            a_fire;
    logic [PX_W-1:0] top_px, mid_px;
    logic [PX_W+1:0] cs [3];
    logic [SUM_W-1:0] sum_a, sum_b, dsum;
    logic [PX_W:0]   d0, d1;

    assign b_ready = !b_valid_reg || c_ready;
    assign a_fire  = a_valid && b_ready;
    assign top_px  = a_item.bank ? a_rd.b1p0 : a_rd.b0p0;
    assign mid_px  = a_item.bank ? a_rd.b0p0 : a_rd.b1p0;
    assign d0      = (PX_W+1)'(a_rd.b0p0) + (PX_W+1)'(a_rd.b1p0);
    assign d1      = (PX_W+1)'(a_rd.b0p1) + (PX_W+1)'(a_rd.b1p1);

    always_comb begin
        win_next = win_reg;
        if (a_fire && !a_item.drain) begin
            for (int r = 0; r < 3; r++) begin
                win_next[r][0] = win_reg[r][1];
                win_next[r][1] = win_reg[r][2];
            end
            win_next[0][2] = top_px;
            win_next[1][2] = mid_px;
            win_next[2][2] = a_item.px;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cs[k] = (a_item.top_cut ? '0 : (PX_W+2)'(win_next[0][k]))
                  + (PX_W+2)'(win_next[1][k]) + (PX_W+2)'(win_next[2][k]);
        end
        sum_a = (a_item.left_cut ? '0 : SUM_W'(cs[0])) + SUM_W'(cs[1]) + SUM_W'(cs[2]);
        sum_b = SUM_W'(cs[1]) + SUM_W'(cs[2]);
        dsum  = (a_item.left_cut ? '0 : SUM_W'(prev_reg)) + SUM_W'(d0)
              + (a_item.right_cut ? '0 : SUM_W'(d1));
    end

    always_comb begin
        b_item_next.row = a_item.row;
        b_item_next.col = a_item.col;
        if (a_item.drain) begin
            b_item_next.two   = 1'b0;
            b_item_next.sum0  = dsum;
            b_item_next.div0  = (a_item.left_cut || a_item.right_cut) ? DIV_4 : DIV_6;
            b_item_next.sum1  = dsum;
            b_item_next.div1  = DIV_4;
            b_item_next.last0 = 1'b1;
            b_item_next.done  = a_item.right_cut;
        end else begin
            b_item_next.two  = a_item.right_cut;
            b_item_next.sum0 = sum_a;
            if (a_item.top_cut && a_item.left_cut) begin
                b_item_next.div0 = DIV_4;
            end else if (a_item.top_cut || a_item.left_cut) begin
                b_item_next.div0 = DIV_6;
            end else begin
                b_item_next.div0 = DIV_9;
            end
            b_item_next.sum1  = sum_b;
            b_item_next.div1  = a_item.top_cut ? DIV_4 : DIV_6;
            b_item_next.last0 = !a_item.right_cut;
            b_item_next.done  = 1'b0;
        end
        if (b_ready) begin
            b_valid_next = a_fire && a_item.has_res;
        end else begin
            b_valid_next = b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    win_reg[r][k] <= '0;
                end
            end
        end else begin
            b_valid_reg <= b_valid_next;
            win_reg     <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_fire) begin
            b_item_reg <= b_item_next;
        end
        if (a_fire && a_item.drain) begin
            prev_reg <= d0;
        end
    end

    assign b_valid = b_valid_reg;
    assign b_item  = b_item_reg;

endmodule

// ===== rtl/bam_divide.sv =====
// Rounded division of the window sums by 4, 6 or 9 via reciprocal multiply.
// Depends on bam_pkg.
module bam_divide import bam_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         b_valid,
    input  sum_pair_t    b_item,
    output logic         c_ready,
    input  logic         q_ready,
    output logic         c_valid,
    output result_pair_t c_item
);

    logic         c_valid_reg, c_valid_next;
    result_pair_t c_item_reg, c_item_next;

    logic [NUM_W-1:0]  num0, num1;
    logic [PROD_W-1:0] prod0, prod1;

    assign c_ready = !c_valid_reg || q_ready;
    assign num0    = {b_item.sum0, 8'h00} + NUM_W'(div_round(b_item.div0));
    assign num1    = {b_item.sum1, 8'h00} + NUM_W'(div_round(b_item.div1));
    assign prod0   = num0 * div_recip(b_item.div0);
    assign prod1   = num1 * div_recip(b_item.div1);

    always_comb begin
        c_item_next.two     = b_item.two;
        c_item_next.r0.mean = prod0[QUOT_LSB +: MEAN_W];
        c_item_next.r0.row  = b_item.row;
        c_item_next.r0.col  = b_item.col;
        c_item_next.r0.last = b_item.last0;
        c_item_next.r0.done = b_item.done;
        c_item_next.r1.mean = prod1[QUOT_LSB +: MEAN_W];
        c_item_next.r1.row  = b_item.row;
        c_item_next.r1.col  = POS_W'(b_item.col + 1'b1);
        c_item_next.r1.last = 1'b1;
        c_item_next.r1.done = 1'b0;
        if (c_ready) begin
            c_valid_next = b_valid;
        end else begin
            c_valid_next = c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else begin
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_valid && c_ready) begin
            c_item_reg <= c_item_next;
        end
    end

    assign c_valid = c_valid_reg;
    assign c_item  = c_item_reg;

endmodule

// ===== rtl/bam_outq.sv =====
// Two-entry result buffer that serializes one or two results per item onto m_.
// Depends on bam_pkg.
module bam_outq import bam_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   c_valid,
    input  result_pair_t           c_item,
    output logic                   q_ready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,
    output logic                   m_tlast,
    output logic [0:0]             m_tuser
);

    logic [1:0] cnt_reg, cnt_next;
    result_t    head_reg, head_next;
    result_t    tail_reg, tail_next;
    logic       pop, push;

    assign pop     = (cnt_reg != 2'd0) && m_tready;
    assign q_ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign push    = c_valid && q_ready;

    always_comb begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (push) begin
            head_next = c_item.r0;
            tail_next = c_item.r1;
            cnt_next  = c_item.two ? 2'd2 : 2'd1;
        end else if (pop) begin
            head_next = tail_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {4'b0000, head_reg.col, head_reg.row, head_reg.mean};
    assign m_tlast  = head_reg.last;
    assign m_tuser  = head_reg.done;

endmodule

// ===== tb/tb_border_aware_mean_3x3.sv =====
`timescale 1ns / 1ps
// Self-checking bench for border_aware_mean_3x3: a directed table, then random frames.
// An in-bench model predicts every 3x3 mean and checks the m_ stream field by field.
// Depends on bam_pkg and the border_aware_mean_3x3 top level.
module tb_border_aware_mean_3x3;
    import bam_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int MAX_H        = 1024;
    localparam bit REQ_SAMPLE   = 1'b0;
    localparam bit REQ_DRAIN    = 1'b1;
    localparam int NO_PIN       = -1;
    localparam int FULL_MEAN    = 65280;
    localparam int SETTLE       = 10;
    localparam int TAIL         = 20;
    localparam int DRAIN_LIMIT  = 50000;
    localparam int RANDOM_ITEMS = 850;
    localparam int LONG_HOLD    = 400;
    localparam int PLAN_LEN     = 27;

    typedef enum logic [1:0] {ACT_SAMPLE, ACT_DRAIN, ACT_SET_W, ACT_SET_H} act_e;
    typedef struct packed {
        act_e act;
        int   value;
        int   pin;
    } plan_row_t;

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_wr_index = '0;
    logic [CFG_W-1:0]       cfg_wr_data  = '0;
    logic                   s_tvalid     = 1'b0;
    logic                   s_tready;
    logic [PX_W-1:0]        s_tdata      = '0;
    logic [0:0]             s_tuser      = '0;
    logic                   m_tvalid;
    logic                   m_tready     = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tlast;
    logic [0:0]             m_tuser;

    // model state
    bit [PX_W-1:0] lstore [2*MAX_W];
    bit [PX_W-1:0] win [3][3];
    int unsigned   row_pos   = 0;
    int unsigned   col_pos   = 0;
    int unsigned   drain_pos = 0;
    bit            draining  = 1'b0;
    int unsigned   reg_w     = FRAME_RESET;
    int unsigned   reg_h     = FRAME_RESET;
    result_t       pending_means [$];

    bit quiet    = 1'b0;
    bit hold_req = 1'b0;
    int mismatches   = 0;
    int items_sent   = 0;
    int taken_items  = 0;
    int results_seen = 0;
    int frames_done  = 0;

    plan_row_t plan [PLAN_LEN] = '{
        '{ACT_SAMPLE, 0,   NO_PIN},
        '{ACT_SAMPLE, 255, NO_PIN},
        '{ACT_DRAIN,  0,   NO_PIN},
        '{ACT_SET_W,  0,   NO_PIN},
        '{ACT_SET_H,  1,   NO_PIN},
        '{ACT_SAMPLE, 0,   0},
        '{ACT_SAMPLE, 0,   0},
        '{ACT_SAMPLE, 0,   0},
        '{ACT_SAMPLE, 0,   0},
        '{ACT_SAMPLE, 255, NO_PIN},
        '{ACT_DRAIN,  0,   0},
        '{ACT_DRAIN,  0,   0},
        '{ACT_DRAIN,  0,   NO_PIN},
        '{ACT_SET_W,  3,   NO_PIN},
        '{ACT_SET_H,  3,   NO_PIN},
        '{ACT_SAMPLE, 255, FULL_MEAN},
        '{ACT_SAMPLE, 255, FULL_MEAN},
        '{ACT_SAMPLE, 255, FULL_MEAN},
        '{ACT_SAMPLE, 255, FULL_MEAN},
        '{ACT_SAMPLE, 255, FULL_MEAN},
        '{ACT_SAMPLE, 255, FULL_MEAN},
        '{ACT_SAMPLE, 255, FULL_MEAN},
        '{ACT_SAMPLE, 255, FULL_MEAN},
        '{ACT_SAMPLE, 255, FULL_MEAN},
        '{ACT_DRAIN,  0,   FULL_MEAN},
        '{ACT_DRAIN,  0,   FULL_MEAN},
        '{ACT_DRAIN,  0,   FULL_MEAN}
    };

    border_aware_mean_3x3 #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned eff_size(int unsigned v, int unsigned top);
        if (v < 2) return 2;
        if (v > top) return top;
        return v;
    endfunction

    function automatic int idle_len();
        int pick;
        if (quiet) return 0;
        pick = $urandom_range(0, 15);
        if (pick < 10) return 0;
        if (pick < 14) return $urandom_range(1, 3);
        if (pick < 15) return $urandom_range(4, 8);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit [PX_W-1:0] pick_height();
        if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
        return PX_W'($urandom_range(0, 255));
    endfunction

    function automatic int unsigned win_sum(int top, int c0);
        int unsigned s;
        s = 0;
        for (int a = top; a < 3; a++)
            for (int b = c0; b < 3; b++)
                s += win[a][b];
        return s;
    endfunction

    function automatic void push_mean(int unsigned s, int unsigned n, int unsigned row,
                                      int unsigned col, bit last, bit done, int pin);
        result_t r;
        r.mean = MEAN_W'((s * 256 + n / 2) / n);
        if (pin != NO_PIN) r.mean = MEAN_W'(pin);
        r.row  = POS_W'(row);
        r.col  = POS_W'(col);
        r.last = last;
        r.done = done;
        pending_means.push_back(r);
    endfunction

    // returns 1 when the transaction is not ignored
    function automatic bit predict_means(bit kind, bit [PX_W-1:0] px, int pin);
        int unsigned w, h, r, c, cur, prv, lo, hi, bt, bb, s;
        int          top, c0;
        bit          at_right;
        w = eff_size(reg_w, MAX_W);
        h = eff_size(reg_h, MAX_H);
        if (kind == REQ_SAMPLE) begin
            if (draining) return 1'b0;
            r   = row_pos;
            c   = (col_pos >= w) ? w - 1 : col_pos;
            cur = (r % 2) * MAX_W + c;
            prv = ((r + 1) % 2) * MAX_W + c;
            for (int a = 0; a < 3; a++) begin
                win[a][0] = win[a][1];
                win[a][1] = win[a][2];
            end
            win[0][2]   = lstore[cur];
            win[1][2]   = lstore[prv];
            win[2][2]   = px;
            lstore[cur] = px;
            if (r >= 1 && c >= 1) begin
                at_right = (c + 1 >= w);
                top      = (r >= 2) ? 0 : 1;
                c0       = (c >= 2) ? 0 : 1;
                push_mean(win_sum(top, c0), (3 - top) * (3 - c0), r - 1, c - 1,
                          !at_right, 1'b0, pin);
                if (at_right)
                    push_mean(win_sum(top, 1), (3 - top) * 2, r - 1, c, 1'b1, 1'b0, pin);
            end
            if (c + 1 >= w) begin
                col_pos = 0;
                if (r + 1 >= h) begin
                    row_pos   = 0;
                    draining  = 1'b1;
                    drain_pos = 0;
                end else begin
                    row_pos = r + 1;
                end
            end else begin
                col_pos = c + 1;
            end
            return 1'b1;
        end
        if (!draining) return 1'b0;
        c  = (drain_pos >= w) ? w - 1 : drain_pos;
        bt = ((h - 2) % 2) * MAX_W;
        bb = ((h - 1) % 2) * MAX_W;
        lo = (c >= 1) ? c - 1 : c;
        hi = (c + 1 < w) ? c + 1 : c;
        s  = 0;
        for (int unsigned x = lo; x <= hi; x++)
            s += lstore[bt + x] + lstore[bb + x];
        push_mean(s, 2 * (hi - lo + 1), h - 1, c, 1'b1, c + 1 >= w, pin);
        if (c + 1 >= w) begin
            draining  = 1'b0;
            drain_pos = 0;
        end else begin
            drain_pos = c + 1;
        end
        return 1'b1;
    endfunction

    task automatic send_item(bit kind, bit [PX_W-1:0] px, int pin);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (predict_means(kind, px, pin)) taken_items++;
    endtask

    // write only when nothing is in flight; a write restarts the frame
    task automatic set_frame_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        s_tvalid <= 1'b0;
        while (pending_means.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= CFG_W'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_FRAME_WIDTH) reg_w = value & 11'h7FF;
        else                        reg_h = value & 11'h7FF;
        row_pos   = 0;
        col_pos   = 0;
        drain_pos = 0;
        draining  = 1'b0;
    endtask

    task automatic feed_frame(bit broken);
        int unsigned w, h, total, cut;
        w     = eff_size(reg_w, MAX_W);
        h     = eff_size(reg_h, MAX_H);
        total = w * h;
        cut   = broken ? $urandom_range(1, total - 1) : total;
        for (int unsigned i = 0; i < cut; i++) begin
            if ($urandom_range(0, 23) == 0) send_item(REQ_DRAIN, PX_W'($urandom), NO_PIN);
            send_item(REQ_SAMPLE, pick_height(), NO_PIN);
        end
        if (broken) return;
        for (int unsigned i = 0; i < w; i++) begin
            if ($urandom_range(0, 23) == 0) send_item(REQ_SAMPLE, pick_height(), NO_PIN);
            send_item(REQ_DRAIN, PX_W'($urandom), NO_PIN);
        end
        if ($urandom_range(0, 7) == 0) send_item(REQ_DRAIN, PX_W'($urandom), NO_PIN);
        frames_done++;
    endtask

    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    initial begin
        int      hold_left;
        int      g;
        result_t want;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (pending_means.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual row %0d col %0d mean %0d",
                             $time, m_tdata[25:16], m_tdata[35:26], m_tdata[15:0]);
                    mismatches++;
                end else begin
                    want = pending_means.pop_front();
                    check_field("mean_value", want.mean, m_tdata[15:0]);
                    check_field("out_row", want.row, m_tdata[25:16]);
                    check_field("out_col", want.col, m_tdata[35:26]);
                    check_field("last_in_run", want.last, m_tlast);
                    check_field("frame_done", want.done, m_tuser[0]);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req && m_tvalid) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else begin
                g = idle_len();
                if (g > 0) begin
                    hold_left = g - 1;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("tb_border_aware_mean_3x3: done, errors");
        $finish;
    end

    initial begin
        int unsigned nframes, wv, hv;
        bit          broken;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            case (plan[i].act)
                ACT_SAMPLE: send_item(REQ_SAMPLE, PX_W'(plan[i].value), plan[i].pin);
                ACT_DRAIN:  send_item(REQ_DRAIN, PX_W'($urandom), plan[i].pin);
                ACT_SET_W:  set_frame_reg(CFG_FRAME_WIDTH, plan[i].value);
                default:    set_frame_reg(CFG_FRAME_HEIGHT, plan[i].value);
            endcase
        end

        // hold the output off early in this frame so the input backs up
        hold_req = 1'b1;
        set_frame_reg(CFG_FRAME_WIDTH, 16);
        set_frame_reg(CFG_FRAME_HEIGHT, 8);
        feed_frame(1'b0);

        taken_items = 0;
        while (taken_items < RANDOM_ITEMS) begin
            quiet = ($urandom_range(0, 4) == 0);
            wv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 16);
            hv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
            case ($urandom_range(0, 3))
                0: set_frame_reg(CFG_FRAME_WIDTH, wv);
                1: set_frame_reg(CFG_FRAME_HEIGHT, hv);
                default: begin
                    set_frame_reg(CFG_FRAME_WIDTH, wv);
                    set_frame_reg(CFG_FRAME_HEIGHT, hv);
                end
            endcase
            nframes = $urandom_range(1, 3);
            for (int unsigned f = 0; f < nframes; f++) begin
                broken = ($urandom_range(0, 7) == 0);
                feed_frame(broken);
                if (broken) break;
            end
        end

        s_tvalid <= 1'b0;
        for (int k = 0; k < DRAIN_LIMIT && pending_means.size() != 0; k++) @(posedge aclk);
        repeat (TAIL) @(posedge aclk);
        if (pending_means.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_means.size());
            mismatches++;
        end

        $display("run: %0d input transactions, %0d results checked, %0d complete frames",
                 items_sent, results_seen, frames_done);
        $display("run: frames from 2x2 to 16x8, undersized writes, restarts, stray ticks, stall");
        if (mismatches == 0) begin
            $display("tb_border_aware_mean_3x3: done, clean");
        end else begin
            $display("tb_border_aware_mean_3x3: done, errors");
        end
        $finish;
    end

endmodule
